// ===== hw/rtl/task_runtime_accumulator_table_defines.svh =====
// assertion macros shared by the task runtime accumulator table
`ifndef TASK_RUNTIME_ACCUMULATOR_TABLE_DEFINES_SVH
`define TASK_RUNTIME_ACCUMULATOR_TABLE_DEFINES_SVH
`ifndef ASSERT_OFF
// antecedent implies consequent in the same cycle
`define TRAT_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);
// antecedent implies consequent in the next cycle
`define TRAT_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);
`else
`define TRAT_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg)
`define TRAT_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg)
`endif
`endif

// ===== hw/rtl/trat_pkg.sv =====
// types, constants and width helpers of the task runtime accumulator table
package trat_pkg;

	localparam int unsigned ENTRIES_DEF = 16;
	localparam logic [4:0] ACTIVE_RESET = 5'd16;
	localparam logic [4:0] MAX_FLUSH = 5'd16;

	typedef enum logic {
		REQ_RECORD = 1'b0,
		REQ_FLUSH  = 1'b1
	} req_type_t;

	typedef enum logic [1:0] {
		ST_HIT   = 2'd0,
		ST_NEW   = 2'd1,
		ST_DROP  = 2'd2,
		ST_FLUSH = 2'd3
	} status_t;

	typedef enum logic {
		SQ_IDLE,
		SQ_FLUSH
	} seq_state_t;

	typedef struct packed {
		req_type_t   req_type;
		logic [31:0] task_id;
		logic [7:0]  time_slice;
		logic [4:0]  flush_count;
	} req_t;

	typedef struct packed {
		status_t     status;
		logic [31:0] entry_id;
		logic [31:0] exec_total;
		logic [31:0] switch_count;
		logic [31:0] overflow_id;
		logic        last;
	} rsp_t;

	// one table entry as held in the memory
	typedef struct packed {
		logic [31:0] id;
		logic [31:0] total;
		logic [31:0] count;
	} rec_t;

	// lookup outcome from the id array
	typedef struct packed {
		logic hit;
		logic full;
	} lkp_t;

	// entry address width
	function automatic int unsigned addr_w(input int unsigned n);
		return (n > 1) ? $clog2(n) : 1;
	endfunction

	// width of a count from zero up to n
	function automatic int unsigned cnt_w(input int unsigned n);
		return $clog2(n + 1);
	endfunction

	// width for comparing counts against the 5-bit size and flush fields
	function automatic int unsigned cmp_w(input int unsigned n);
		return (cnt_w(n) > 5) ? cnt_w(n) : 5;
	endfunction

endpackage

// ===== hw/rtl/task_runtime_accumulator_table.sv =====
// top level of the task runtime accumulator table
`include "task_runtime_accumulator_table_defines.svh"

// Per-task runtime table. A record request is looked up against all ids in
// parallel in the cycle it is accepted; the id array, fill count and overflow
// id are updated at that edge, and the entry totals then go through a
// read-modify-write of the entry memory in stage 1 (read) and stage 2
// (modify and write back) before the result register. A new request is not
// taken while stage 1 holds one. A flush emits n entries (n = 1 to 16): they
// are read one per cycle, while the result path does not stall, through the
// single read port of the memory. The table is cleared by resetting the fill
// count, so no clearing pass is needed after reset or flush. A full result
// register blocks the pipeline until the result transaction completes. The
// size register is written through cfg_data with cfg_ready always high.
module task_runtime_accumulator_table #(
	parameter int unsigned ENTRIES = trat_pkg::ENTRIES_DEF
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           req_valid,
	output logic           req_stall,
	input  trat_pkg::req_t req,
	output logic           rsp_valid,
	input  logic           rsp_stall,
	output trat_pkg::rsp_t rsp,
	input  logic           cfg_valid,
	output logic           cfg_ready,
	input  logic [4:0]     cfg_data
);
	import trat_pkg::*;

	localparam int unsigned AW = addr_w(ENTRIES);
	localparam int unsigned FW = cnt_w(ENTRIES);
	localparam int unsigned CW = cmp_w(ENTRIES);

	logic [4:0]    act_q;
	logic [CW-1:0] size;

	lkp_t          lkp;
	logic [AW-1:0] cam_idx;
	logic [FW-1:0] cam_fill;
	logic [31:0]   cam_ovf;

	logic          req_acc;
	logic          load_rec;
	logic          flush_acc;
	logic [4:0]    flush_n;

	seq_state_t    sq_state_q;
	seq_state_t    sq_next;
	logic          issue;
	logic [4:0]    k_q;
	logic [4:0]    n_q;
	logic [FW-1:0] fill_snap_q;
	logic [31:0]   ovf_snap_q;
	logic [CW-1:0] k_x;

	logic          v_s1;
	status_t       st_s1;
	logic [AW-1:0] addr_s1;
	logic [31:0]   id_s1;
	logic [7:0]    slice_s1;
	logic [31:0]   ovf_s1;
	logic          zero_s1;
	logic          last_s1;
	logic          s1_adv;

	logic          v_s2;
	status_t       st_s2;
	logic [AW-1:0] addr_s2;
	logic [31:0]   id_s2;
	logic [7:0]    slice_s2;
	logic [31:0]   ovf_s2;
	logic          zero_s2;
	logic          last_s2;
	logic          s2_adv;

	rec_t          rd_data;
	rec_t          wr_data;
	logic          wr_en;
	logic [31:0]   tot;
	logic [31:0]   sw;
	logic [31:0]   eid;

	logic          rsp_valid_q;
	rsp_t          rsp_q;

	// size register; the size in use is saturated to the table depth
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			act_q <= ACTIVE_RESET;
		end else if (cfg_valid && cfg_ready) begin
			act_q <= cfg_data;
		end
	end

	assign cfg_ready = 1'b1;
	assign size = (CW'(act_q) > CW'(ENTRIES)) ? CW'(ENTRIES) : CW'(act_q);

	// request transaction
	assign req_stall = v_s1 || (sq_state_q != SQ_IDLE);
	assign req_acc   = req_valid && !req_stall;
	assign load_rec  = req_acc && (req.req_type == REQ_RECORD);
	assign flush_acc = req_acc && (req.req_type == REQ_FLUSH);

	always_comb begin
		if (req.flush_count == 5'd0) begin
			flush_n = 5'd1;
		end else if (req.flush_count > MAX_FLUSH) begin
			flush_n = MAX_FLUSH;
		end else begin
			flush_n = req.flush_count;
		end
	end

	trat_cam #(
		.ENTRIES(ENTRIES)
	) u_cam (
		.clk     (clk),
		.arst_n  (arst_n),
		.size    (size),
		.look_id (req.task_id),
		.rec_en  (load_rec),
		.clr     (flush_acc),
		.lkp     (lkp),
		.idx     (cam_idx),
		.fill    (cam_fill),
		.ovf     (cam_ovf)
	);

	// flush sequencer state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sq_state_q <= SQ_IDLE;
		end else begin
			sq_state_q <= sq_next;
		end
	end

	// flush sequencer next state, one entry read issued per free slot
	always_comb begin
		sq_next = sq_state_q;
		issue   = 1'b0;
		case (sq_state_q)
			SQ_IDLE: begin
				if (flush_acc) begin
					sq_next = SQ_FLUSH;
				end
			end
			SQ_FLUSH: begin
				issue = !v_s1 || s1_adv;
				if (issue && (k_q == n_q - 5'd1)) begin
					sq_next = SQ_IDLE;
				end
			end
			default: begin
				sq_next = SQ_IDLE;
			end
		endcase
	end

	// flush counter and snapshot of the table before the clear
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			k_q <= '0;
		end else if (flush_acc) begin
			k_q <= '0;
		end else if (issue) begin
			k_q <= k_q + 5'd1;
		end
	end

	always_ff @(posedge clk) begin
		if (flush_acc) begin
			n_q         <= flush_n;
			fill_snap_q <= cam_fill;
			ovf_snap_q  <= cam_ovf;
		end
	end

	assign k_x = CW'(k_q);

	// stage 1: memory read
	assign s1_adv = v_s1 && (!v_s2 || s2_adv);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (load_rec || issue) begin
			v_s1 <= 1'b1;
		end else if (s1_adv) begin
			v_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load_rec) begin
			if (lkp.hit) begin
				st_s1   <= ST_HIT;
				addr_s1 <= cam_idx;
			end else if (lkp.full) begin
				st_s1   <= ST_DROP;
				addr_s1 <= cam_idx;
			end else begin
				st_s1   <= ST_NEW;
				addr_s1 <= cam_fill[AW-1:0];
			end
			id_s1    <= req.task_id;
			slice_s1 <= req.time_slice;
			ovf_s1   <= lkp.full ? req.task_id : cam_ovf;
			zero_s1  <= 1'b0;
			last_s1  <= 1'b1;
		end else if (issue) begin
			st_s1    <= ST_FLUSH;
			addr_s1  <= k_x[AW-1:0];
			id_s1    <= '0;
			slice_s1 <= '0;
			ovf_s1   <= ovf_snap_q;
			zero_s1  <= !(k_x < CW'(fill_snap_q));
			last_s1  <= (k_q == n_q - 5'd1);
		end
	end

	trat_mem #(
		.ENTRIES(ENTRIES)
	) u_mem (
		.clk     (clk),
		.rd_en   (s1_adv),
		.rd_addr (addr_s1),
		.rd_data (rd_data),
		.wr_en   (wr_en),
		.wr_addr (addr_s2),
		.wr_data (wr_data)
	);

	// stage 2: modify, write back and form the result
	assign s2_adv = v_s2 && (!rsp_valid_q || !rsp_stall);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2 <= 1'b0;
		end else if (s1_adv) begin
			v_s2 <= 1'b1;
		end else if (s2_adv) begin
			v_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (s1_adv) begin
			st_s2    <= st_s1;
			addr_s2  <= addr_s1;
			id_s2    <= id_s1;
			slice_s2 <= slice_s1;
			ovf_s2   <= ovf_s1;
			zero_s2  <= zero_s1;
			last_s2  <= last_s1;
		end
	end

	always_comb begin
		tot = '0;
		sw  = '0;
		eid = id_s2;
		case (st_s2)
			ST_HIT: begin
				tot = rd_data.total + 32'(slice_s2);
				sw  = rd_data.count + 32'd1;
			end
			ST_NEW: begin
				tot = 32'(slice_s2);
				sw  = 32'd1;
			end
			ST_DROP: begin
				tot = '0;
				sw  = '0;
			end
			ST_FLUSH: begin
				tot = zero_s2 ? 32'd0 : rd_data.total;
				sw  = zero_s2 ? 32'd0 : rd_data.count;
				eid = zero_s2 ? 32'd0 : rd_data.id;
			end
			default: begin
				tot = '0;
				sw  = '0;
			end
		endcase
	end

	assign wr_en         = s2_adv && ((st_s2 == ST_HIT) || (st_s2 == ST_NEW));
	assign wr_data.id    = id_s2;
	assign wr_data.total = tot;
	assign wr_data.count = sw;

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (s2_adv) begin
			rsp_valid_q <= 1'b1;
		end else if (!rsp_stall) begin
			rsp_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (s2_adv) begin
			rsp_q.status       <= st_s2;
			rsp_q.entry_id     <= eid;
			rsp_q.exec_total   <= tot;
			rsp_q.switch_count <= sw;
			rsp_q.overflow_id  <= ovf_s2;
			rsp_q.last         <= last_s2;
		end
	end

	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

	// checks on the pipeline and the flush sequencer
	`TRAT_ASSERT_IMP(a_rsp_from_s2, clk, arst_n, $rose(rsp_valid_q), $past(v_s2), "result without stage 2")
	`TRAT_ASSERT_NEXT(a_rec_to_s1, clk, arst_n, load_rec, v_s1 && (st_s1 != ST_FLUSH), "record lost")
	`TRAT_ASSERT_NEXT(a_flush_start, clk, arst_n, flush_acc, (sq_state_q == SQ_FLUSH) && (k_q == 5'd0), "flush not started")

endmodule

// ===== hw/rtl/trat_cam.sv =====
// id array with parallel lookup, fill count and overflow id
module trat_cam #(
	parameter int unsigned ENTRIES = trat_pkg::ENTRIES_DEF
) (
	input  logic                                   clk,
	input  logic                                   arst_n,
	input  logic [trat_pkg::cmp_w(ENTRIES)-1:0]    size,
	input  logic [31:0]                            look_id,
	input  logic                                   rec_en,
	input  logic                                   clr,
	output trat_pkg::lkp_t                         lkp,
	output logic [trat_pkg::addr_w(ENTRIES)-1:0]   idx,
	output logic [trat_pkg::cnt_w(ENTRIES)-1:0]    fill,
	output logic [31:0]                            ovf
);
	import trat_pkg::*;

	localparam int unsigned AW = addr_w(ENTRIES);
	localparam int unsigned FW = cnt_w(ENTRIES);
	localparam int unsigned CW = cmp_w(ENTRIES);

	logic [31:0]        ids_q [ENTRIES];
	logic [FW-1:0]      fill_q;
	logic [31:0]        ovf_q;
	logic [ENTRIES-1:0] match;
	logic [CW-1:0]      fill_x;

	assign fill_x = CW'(fill_q);

	// compare every searched entry against the requested id
	always_comb begin
		for (int i = 0; i < ENTRIES; i++) begin
			match[i] = (ids_q[i] == look_id) && (CW'(i) < fill_x) && (CW'(i) < size);
		end
	end

	// lowest matching entry wins
	always_comb begin
		idx = '0;
		for (int i = ENTRIES - 1; i >= 0; i--) begin
			if (match[i]) begin
				idx = AW'(i);
			end
		end
	end

	assign lkp.hit  = |match;
	assign lkp.full = (fill_x >= size);
	assign fill     = fill_q;
	assign ovf      = ovf_q;

	// id of a newly filled entry
	always_ff @(posedge clk) begin
		if (rec_en && !lkp.hit && !lkp.full) begin
			ids_q[fill_q[AW-1:0]] <= look_id;
		end
	end

	// fill count and overflow id
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fill_q <= '0;
			ovf_q  <= '0;
		end else if (clr) begin
			fill_q <= '0;
			ovf_q  <= '0;
		end else if (rec_en) begin
			if (lkp.full) begin
				ovf_q <= look_id;
			end else if (!lkp.hit) begin
				fill_q <= fill_q + 1'b1;
			end
		end
	end

endmodule

// ===== hw/rtl/trat_mem.sv =====
// entry memory with registered read and write-to-read forwarding
module trat_mem #(
	parameter int unsigned ENTRIES = trat_pkg::ENTRIES_DEF
) (
	input  logic                                 clk,
	input  logic                                 rd_en,
	input  logic [trat_pkg::addr_w(ENTRIES)-1:0] rd_addr,
	output trat_pkg::rec_t                       rd_data,
	input  logic                                 wr_en,
	input  logic [trat_pkg::addr_w(ENTRIES)-1:0] wr_addr,
	input  trat_pkg::rec_t                       wr_data
);
	import trat_pkg::*;

	rec_t mem_q [ENTRIES];
	rec_t rd_q;

	// write port
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
	end

	// read port, same-edge write to the same entry is forwarded
	always_ff @(posedge clk) begin
		if (rd_en) begin
			if (wr_en && (wr_addr == rd_addr)) begin
				rd_q <= wr_data;
			end else begin
				rd_q <= mem_q[rd_addr];
			end
		end
	end

	assign rd_data = rd_q;

endmodule
